FILE: src/dlfv_pkg.sv
// dlfv_pkg: types and constants shared by the fill valve control block.
// Configuration register indexes, reset values and the configuration bundle.
// No dependencies.
package dlfv_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENSORS_PRESENT = 2'd0,
    REG_SAMPLE_INTERVAL = 2'd1,
    REG_DEBOUNCE        = 2'd2
  } cfg_reg_e;

  localparam logic                 SensorsPresentRst = 1'b1;
  localparam logic [IntervalW-1:0] SampleIntervalRst = 16'd100;
  localparam logic [IntervalW-1:0] DebounceRst       = 16'd50;

  typedef struct packed {
    logic                 sensors_present;
    logic [IntervalW-1:0] sample_interval_ms;
    logic [IntervalW-1:0] debounce_ms;
  } cfg_t;

endpackage

FILE: src/debounced_level_fill_valve.sv
// debounced_level_fill_valve: two-level-switch fill valve control, top level.
// Depends on dlfv_pkg, dlfv_cfg_regs and dlfv_debounce.
//
//   channel | valid / ready              | payload
//   --------+----------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o    | now_ms_i, top_sensor_i, bottom_sensor_i
//   out     | out_valid_o / out_ready_i  | sampled_o, valve_open_o, valve_drive_o,
//           |                            | reservoir_empty_o, top_level_stable_o,
//           |                            | bottom_level_stable_o
//   cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One poll per cycle while the result register is not stalled. A poll is held in
// the input register, evaluated against the state and written to the result
// register. The state updates as the poll moves into the result register, so
// consecutive polls see each other's effect. A stalled result register holds
// the input register, and in_ready_o drops. Reset clears the valid flags and
// control state; config and result fields take their reset values.
module debounced_level_fill_valve (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dlfv_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          top_sensor_i,
  input  logic                          bottom_sensor_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          sampled_o,
  output logic                          valve_open_o,
  output logic                          valve_drive_o,
  output logic                          reservoir_empty_o,
  output logic                          top_level_stable_o,
  output logic                          bottom_level_stable_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dlfv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dlfv_pkg::CfgDataW-1:0] cfg_data_i
);
  import dlfv_pkg::*;

  cfg_t cfg;

  // input stage
  logic             in_vld_q;
  logic [TimeW-1:0] now_q;
  logic             top_raw_q, bot_raw_q;

  // control state
  logic [TimeW-1:0] last_check_q, last_check_d;
  logic             valve_q, valve_d;
  logic             empty_q, empty_d;

  // result stage
  logic res_vld_q, res_vld_d;
  logic res_sampled_q, res_valve_q, res_empty_q, res_top_q, res_bot_q;

  logic             advance;
  logic             check;
  logic [TimeW-1:0] since_check;
  logic             top_lvl, bot_lvl;

  dlfv_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance    = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  assign since_check = now_q - last_check_q;
  assign check = advance && cfg.sensors_present &&
                 (since_check >= {{(TimeW-IntervalW){1'b0}}, cfg.sample_interval_ms});

  dlfv_debounce u_top_db (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (check),
    .raw_i        (top_raw_q),
    .now_i        (now_q),
    .debounce_ms_i(cfg.debounce_ms),
    .stable_d_o   (top_lvl)
  );

  dlfv_debounce u_bot_db (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (check),
    .raw_i        (bot_raw_q),
    .now_i        (now_q),
    .debounce_ms_i(cfg.debounce_ms),
    .stable_d_o   (bot_lvl)
  );

  always_comb begin
    last_check_d = last_check_q;
    valve_d      = valve_q;
    empty_d      = empty_q;
    if (check) begin
      last_check_d = now_q;
      if (!top_lvl && bot_lvl) begin
        valve_d = 1'b1;  // empty: start filling
        empty_d = 1'b1;
      end else if (top_lvl && !bot_lvl) begin
        valve_d = 1'b0;  // full: stop
        empty_d = 1'b0;
      end
    end
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (advance) begin
      res_vld_d = 1'b1;
    end else if (out_ready_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      res_vld_q    <= 1'b0;
      last_check_q <= '0;
      valve_q      <= 1'b0;
      empty_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      res_vld_q    <= res_vld_d;
      last_check_q <= last_check_d;
      valve_q      <= valve_d;
      empty_q      <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q     <= now_ms_i;
      top_raw_q <= top_sensor_i;
      bot_raw_q <= bottom_sensor_i;
    end
  end

  // result fields start at the post-reset state, so the drive pin reads closed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_sampled_q <= 1'b0;
      res_valve_q   <= 1'b0;
      res_empty_q   <= 1'b0;
      res_top_q     <= 1'b1;
      res_bot_q     <= 1'b1;
    end else if (advance) begin
      res_sampled_q <= check;
      res_valve_q   <= valve_d;
      res_empty_q   <= empty_d;
      res_top_q     <= top_lvl;
      res_bot_q     <= bot_lvl;
    end
  end

  assign out_valid_o           = res_vld_q;
  assign sampled_o             = res_sampled_q;
  assign valve_open_o          = res_valve_q;
  assign valve_drive_o         = ~res_valve_q;  // pin is active low
  assign reservoir_empty_o     = res_empty_q;
  assign top_level_stable_o    = res_top_q;
  assign bottom_level_stable_o = res_bot_q;

endmodule

FILE: src/dlfv_cfg_regs.sv
// dlfv_cfg_regs: configuration register file of the fill valve control.
// Depends on dlfv_pkg. Writes to unknown indexes are dropped.
module dlfv_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dlfv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dlfv_pkg::CfgDataW-1:0] cfg_data_i,
  output dlfv_pkg::cfg_t                cfg_o
);
  import dlfv_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SENSORS_PRESENT: cfg_d.sensors_present    = cfg_data_i[0];
        REG_SAMPLE_INTERVAL: cfg_d.sample_interval_ms = cfg_data_i[IntervalW-1:0];
        REG_DEBOUNCE:        cfg_d.debounce_ms        = cfg_data_i[IntervalW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensors_present    <= SensorsPresentRst;
      cfg_q.sample_interval_ms <= SampleIntervalRst;
      cfg_q.debounce_ms        <= DebounceRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/dlfv_debounce.sv
// dlfv_debounce: debouncer for one level switch, updated on each level check.
// Depends on dlfv_pkg. stable_d_o gives the level after the current check.
module dlfv_debounce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           sample_i,
  input  logic                           raw_i,
  input  logic [dlfv_pkg::TimeW-1:0]     now_i,
  input  logic [dlfv_pkg::IntervalW-1:0] debounce_ms_i,
  output logic                           stable_d_o
);
  import dlfv_pkg::*;

  logic             last_q, last_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] change_q, change_d;
  logic [TimeW-1:0] held;

  assign held = now_i - change_q;

  always_comb begin
    last_d   = last_q;
    stable_d = stable_q;
    change_d = change_q;
    if (sample_i) begin
      if (raw_i != last_q) begin
        last_d   = raw_i;
        change_d = now_i;
      end else if (held >= {{(TimeW-IntervalW){1'b0}}, debounce_ms_i}) begin
        stable_d = raw_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b1;
      stable_q <= 1'b1;
      change_q <= '0;
    end else begin
      last_q   <= last_d;
      stable_q <= stable_d;
      change_q <= change_d;
    end
  end

  assign stable_d_o = stable_d;

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for debounced_level_fill_valve, polls checked against a predictor.
// Depends on dlfv_pkg and the debounced_level_fill_valve RTL.
`timescale 1ns / 1ps

module tb;
  import dlfv_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 2'd3;
  localparam int unsigned StallMax  = 14;
  localparam int unsigned HoldOff   = 300;
  localparam int unsigned HoldAt    = 700;
  localparam int unsigned StuckMax  = 2000;
  localparam int unsigned TailWait  = 8;

  typedef struct packed {
    logic sampled;
    logic valve_open;
    logic valve_drive;
    logic reservoir_empty;
    logic top_stable;
    logic bot_stable;
  } result_t;

  typedef struct packed {
    logic        last;
    logic        stable;
    logic [31:0] t_change;
  } sw_t;

  typedef struct packed {
    logic [31:0] t;
    logic        top;
    logic        bot;
    logic        pinned;
    result_t     want;
  } row_t;

  // Reset config throughout; pinned rows carry {sampled,open,drive,empty,top,bot}
  localparam row_t Script [14] = '{
    {32'd0,          1'b1, 1'b1, 1'b1, 6'b001011},
    {32'd100,        1'b0, 1'b1, 1'b1, 6'b101011},
    {32'd150,        1'b0, 1'b1, 1'b1, 6'b001011},
    {32'd200,        1'b0, 1'b1, 1'b1, 6'b110101},
    {32'd300,        1'b1, 1'b0, 1'b0, 6'b000000},
    {32'd400,        1'b1, 1'b0, 1'b1, 6'b101010},
    {32'hFFFF_FFFF,  1'b1, 1'b0, 1'b1, 6'b101010},
    {32'd98,         1'b1, 1'b0, 1'b1, 6'b001010},
    {32'd99,         1'b0, 1'b1, 1'b0, 6'b000000},
    {32'd199,        1'b0, 1'b1, 1'b0, 6'b000000},
    {32'd299,        1'b0, 1'b0, 1'b0, 6'b000000},
    {32'd399,        1'b0, 1'b0, 1'b0, 6'b000000},
    {32'd499,        1'b1, 1'b1, 1'b0, 6'b000000},
    {32'd599,        1'b1, 1'b1, 1'b0, 6'b000000}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic [TimeW-1:0]    now_ms = '0;
  logic                top_raw = 1'b0;
  logic                bot_raw = 1'b0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                pin_valid = 1'b0;
  result_t             pin_res = '0;

  logic in_ready_o, out_valid_o, cfg_ready_o;
  logic sampled_o, valve_open_o, valve_drive_o, reservoir_empty_o;
  logic top_level_stable_o, bottom_level_stable_o;

  debounced_level_fill_valve u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready_o),
    .now_ms_i              (now_ms),
    .top_sensor_i          (top_raw),
    .bottom_sensor_i       (bot_raw),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready),
    .sampled_o             (sampled_o),
    .valve_open_o          (valve_open_o),
    .valve_drive_o         (valve_drive_o),
    .reservoir_empty_o     (reservoir_empty_o),
    .top_level_stable_o    (top_level_stable_o),
    .bottom_level_stable_o (bottom_level_stable_o),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data)
  );

  // predictor state, matching the block after reset
  logic                 cfg_present  = SensorsPresentRst;
  logic [IntervalW-1:0] cfg_interval = SampleIntervalRst;
  logic [IntervalW-1:0] cfg_debounce = DebounceRst;
  logic [31:0]          chk_time = '0;
  sw_t                  top_sw = {1'b1, 1'b1, 32'd0};
  sw_t                  bot_sw = {1'b1, 1'b1, 32'd0};
  logic                 valve_q = 1'b0;
  logic                 empty_q = 1'b0;

  result_t     level_q [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned checks_seen = 0;
  int unsigned polls_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned stuck = 0;
  logic        src_quiet = 1'b0;
  logic        sink_quiet = 1'b0;

  function automatic sw_t debounce_next(sw_t sw, logic raw, logic [31:0] t);
    sw_t         nxt;
    logic [31:0] held;
    nxt  = sw;
    held = t - sw.t_change;
    if (raw != sw.last) begin
      nxt.last     = raw;
      nxt.t_change = t;
    end else if (held >= {16'd0, cfg_debounce}) begin
      nxt.stable = raw;
    end
    return nxt;
  endfunction

  function automatic result_t level_check(logic [31:0] t, logic top, logic bot);
    result_t     r;
    logic [31:0] since;
    since     = t - chk_time;
    r.sampled = 1'b0;
    if (cfg_present && since >= {16'd0, cfg_interval}) begin
      r.sampled = 1'b1;
      chk_time  = t;
      top_sw    = debounce_next(top_sw, top, t);
      bot_sw    = debounce_next(bot_sw, bot, t);
      if (!top_sw.stable && bot_sw.stable) begin
        valve_q = 1'b1;
        empty_q = 1'b1;
      end else if (top_sw.stable && !bot_sw.stable) begin
        valve_q = 1'b0;
        empty_q = 1'b0;
      end
    end
    r.valve_open      = valve_q;
    r.valve_drive     = ~valve_q;
    r.reservoir_empty = empty_q;
    r.top_stable      = top_sw.stable;
    r.bot_stable      = bot_sw.stable;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    if (mismatches < 40) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin : scoreboard
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        reg_writes++;
        case (cfg_index)
          REG_SENSORS_PRESENT: cfg_present  = cfg_data[0];
          REG_SAMPLE_INTERVAL: cfg_interval = cfg_data;
          REG_DEBOUNCE:        cfg_debounce = cfg_data;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready) begin
        got = {sampled_o, valve_open_o, valve_drive_o, reservoir_empty_o,
               top_level_stable_o, bottom_level_stable_o};
        results_seen++;
        if (sampled_o) checks_seen++;
        if (level_q.size() == 0) begin
          note_mismatch("result beat with nothing expected");
        end else begin
          want = level_q.pop_front();
          if (got.sampled !== want.sampled)
            note_mismatch($sformatf("sampled %b, want %b", got.sampled, want.sampled));
          if (got.valve_open !== want.valve_open)
            note_mismatch($sformatf("valve_open %b, want %b", got.valve_open,
                                    want.valve_open));
          if (got.valve_drive !== want.valve_drive)
            note_mismatch($sformatf("valve_drive %b, want %b", got.valve_drive,
                                    want.valve_drive));
          if (got.reservoir_empty !== want.reservoir_empty)
            note_mismatch($sformatf("reservoir_empty %b, want %b", got.reservoir_empty,
                                    want.reservoir_empty));
          if (got.top_stable !== want.top_stable)
            note_mismatch($sformatf("top_level_stable %b, want %b", got.top_stable,
                                    want.top_stable));
          if (got.bot_stable !== want.bot_stable)
            note_mismatch($sformatf("bottom_level_stable %b, want %b", got.bot_stable,
                                    want.bot_stable));
        end
      end
      if (in_valid && in_ready_o) begin
        want = level_check(now_ms, top_raw, bot_raw);
        if (pin_valid) want = pin_res;
        level_q.push_back(want);
      end
    end
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
        stuck <= 0;
      else
        stuck <= stuck + 1;
      if (stuck == StuckMax) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result sink: random stalls, quiet stretches, one long hold-off
  initial begin : sink
    int unsigned stall;
    int unsigned beats;
    logic        held_off;
    beats    = 0;
    held_off = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held_off && results_seen >= HoldAt) begin
        stall    = HoldOff;
        held_off = 1'b1;
      end else begin
        stall = sink_quiet ? 0 : $urandom_range(0, StallMax);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      beats++;
      if (beats % 37 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic offer_poll(logic [31:0] t, logic top, logic bot, logic pin, result_t pinned);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, StallMax);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    now_ms    <= t;
    top_raw   <= top;
    bot_raw   <= bot;
    pin_valid <= pin;
    pin_res   <= pinned;
    do @(posedge clk_i); while (!in_ready_o);
    polls_sent++;
    if (polls_sent % 40 == 0) src_quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain_levels();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // leaves cfg_valid high so back-to-back writes never lower and raise it in one step
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_settings(logic [15:0] present_word, logic [15:0] interval,
                               logic [15:0] debounce);
    drain_levels();
    write_reg(REG_SENSORS_PRESENT, present_word);
    write_reg(REG_SAMPLE_INTERVAL, interval);
    write_reg(REG_DEBOUNCE, debounce);
    cfg_valid <= 1'b0;
  endtask

  // Tank-like sequences: a switch pair held for a few polls, with odd bounces,
  // and some noise polls that jump the clock anywhere, wrap included.
  task automatic run_polls(int n, int unsigned span, int pause_at);
    logic [31:0] clock_ms;
    logic [1:0]  level;
    logic [1:0]  raw;
    int unsigned hold_left;
    clock_ms  = $urandom;
    level     = 2'b11;
    hold_left = 0;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain_levels();
      if (hold_left == 0) begin
        case ($urandom_range(0, 5))
          0, 1:    level = 2'b01;
          2, 3:    level = 2'b10;
          4:       level = 2'b11;
          default: level = 2'b00;
        endcase
        hold_left = $urandom_range(1, 10);
      end
      hold_left--;
      raw = level;
      if ($urandom_range(0, 7) == 0) raw = raw ^ (2'b01 << $urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2 * span)
                                               : $urandom;
        raw = 2'($urandom_range(0, 3));
      end else begin
        clock_ms = clock_ms + $urandom_range(0, span + span / 2 + 4);
      end
      offer_poll(clock_ms, raw[1], raw[0], 1'b0, '0);
    end
  endtask

  function automatic int unsigned step_span(logic [15:0] interval, logic [15:0] debounce);
    return (interval > (debounce >> 2)) ? interval : (debounce >> 2);
  endfunction

  initial begin : source
    logic [15:0] rand_interval;
    logic [15:0] rand_debounce;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    foreach (Script[i])
      offer_poll(Script[i].t, Script[i].top, Script[i].bot, Script[i].pinned, Script[i].want);
    run_polls(200, step_span(SampleIntervalRst, DebounceRst), -1);

    // zero interval and debounce; a write to the unmapped index must do nothing
    drain_levels();
    write_reg(REG_UNMAPPED, 16'hFFFF);
    write_reg(REG_SENSORS_PRESENT, 16'h0001);
    write_reg(REG_SAMPLE_INTERVAL, 16'h0000);
    write_reg(REG_DEBOUNCE, 16'h0000);
    cfg_valid <= 1'b0;
    run_polls(260, 4, 130);

    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_polls(240, step_span(16'hFFFF, 16'hFFFF), -1);

    // only bit 0 of the presence register counts: sensors absent here
    load_settings(16'hFFFE, 16'd37, 16'd12);
    run_polls(150, step_span(16'd37, 16'd12), -1);

    rand_interval = 16'($urandom_range(1, 400));
    rand_debounce = 16'($urandom_range(0, 200));
    load_settings(16'h8001, rand_interval, rand_debounce);
    run_polls(300, step_span(rand_interval, rand_debounce), -1);

    load_settings(16'h0001, 16'd0, 16'hFFFF);
    run_polls(300, step_span(16'd0, 16'hFFFF), -1);

    drain_levels();
    repeat (TailWait) @(posedge clk_i);
    if (level_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", level_q.size()));
    $display("Run: %0d polls, %0d result beats, %0d level checks, %0d register writes.",
             polls_sent, results_seen, checks_seen, reg_writes);
    $display("Six register settings incl. zero and full-scale timings, sensors absent, wrap.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/dlfv_pkg.sv
src/dlfv_cfg_regs.sv
src/dlfv_debounce.sv
src/debounced_level_fill_valve.sv
verif/tb.sv
